### src/nbpd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// nbpd_pkg - shared types and constants of the netpbm pixel decoder
// Register indexes, sample widths and the raster tag passed between the
// position tracker and the sequencer.
// ============================================================================
package nbpd_pkg;

    // Sample and register widths
    localparam int SAMPLE_W   = 8;
    localparam int DIM_W      = 13;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int RUN_W      = 4;   // holds a run length of 1 to 8 pixels
    localparam int BIT_IDX_W  = 3;

    localparam logic [SAMPLE_W-1:0] SAMPLE_FULL   = 8'd255;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO   = 8'd0;
    localparam logic [RUN_W-1:0]    BITS_PER_BYTE = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PIXELS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_TOTAL  = 2'd3;

    // Pixel modes
    localparam logic [MODE_W-1:0] MODE_BITMAP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGB    = 2'd2;

    // Reset values of the registers
    localparam logic [MODE_W-1:0]   RST_PIXEL_MODE = MODE_RGB;
    localparam logic [SAMPLE_W-1:0] RST_MAX_SAMPLE = 8'd255;
    localparam logic [DIM_W-1:0]    RST_ROW_PIXELS = 13'd640;
    localparam logic [DIM_W-1:0]    RST_ROW_TOTAL  = 13'd480;

    // Position tags of the pixel being emitted
    typedef struct packed {
        logic row_end;
        logic image_end;
    } t_raster_tag;

endpackage

### src/netpbm_binary_pixel_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// netpbm_binary_pixel_decoder - raw PBM/PGM/PPM raster to RGB pixels
// Sequencer around one shared iterative scaler and a raster tracker.
// ============================================================================
// Usage:
//   Raster bytes enter on i_valid/o_ready with i_data_byte; pixels leave on
//   o_valid/i_ready with RGB, row end, image end, saturation and a flag on
//   the last pixel of each byte. The header is written beforehand through
//   i_cfg_we/i_cfg_index/i_cfg_data while the block is idle.
//   Bitmap: a byte gives 1 to 8 pixels at one per cycle unless the receiver
//   stalls; the held byte is shifted out one bit per pixel.
//   Gray: one pass of the 8-step scaler, then the pixel is presented and
//   the next byte can be taken.
//   RGB: the first two bytes are only held; the third runs three scaler
//   passes back to back, then the pixel is presented and the next byte is
//   taken.
//   The scaler divides one quotient bit per cycle. One byte is in work at a
//   time; o_ready is low meanwhile.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset restores the header defaults (rgb, 255, 640 x 480), clears the
//   raster position, the RGB gathering phase and the output valid.
// ============================================================================
module netpbm_binary_pixel_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [nbpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nbpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // raster bytes
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [nbpd_pkg::SAMPLE_W-1:0]      i_data_byte,
    // pixels
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [nbpd_pkg::SAMPLE_W-1:0]      o_red,
    output logic [nbpd_pkg::SAMPLE_W-1:0]      o_green,
    output logic [nbpd_pkg::SAMPLE_W-1:0]      o_blue,
    output logic                               o_row_end,
    output logic                               o_image_end,
    output logic                               o_over_max,
    output logic                               o_run_last
);
    import nbpd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EMIT = 4'b0100,
        S_BITS = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    // Configuration registers
    logic [MODE_W-1:0]   r_pixel_mode;
    logic [SAMPLE_W-1:0] r_max_sample;
    logic [DIM_W-1:0]    r_row_pixels;
    logic [DIM_W-1:0]    r_row_total;

    // Sequencer state
    t_state              r_state;
    t_chan               r_chan;
    logic [1:0]          r_phase;
    logic [SAMPLE_W-1:0] r_held_red;
    logic [SAMPLE_W-1:0] r_held_green;
    logic [SAMPLE_W-1:0] r_byte;
    logic                r_gray;
    logic                r_over;
    logic [SAMPLE_W-1:0] r_red_q;
    logic [SAMPLE_W-1:0] r_green_q;
    logic [SAMPLE_W-1:0] r_blue_q;
    logic [BIT_IDX_W-1:0] r_bit_idx;
    logic [BIT_IDX_W-1:0] r_bit_last;
    logic                r_out_valid;

    logic                accept;
    logic                out_free;
    logic                emit;
    logic                div_start;
    logic [SAMPLE_W-1:0] div_sample;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quot;
    logic                div_over;
    t_raster_tag         tag;
    logic [RUN_W-1:0]    run_len;
    logic [SAMPLE_W-1:0] bit_val;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign emit     = out_free && ((r_state == S_EMIT) || (r_state == S_BITS));
    assign bit_val  = r_byte[SAMPLE_W-1] ? SAMPLE_FULL : SAMPLE_ZERO;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode <= RST_PIXEL_MODE;
            r_max_sample <= RST_MAX_SAMPLE;
            r_row_pixels <= RST_ROW_PIXELS;
            r_row_total  <= RST_ROW_TOTAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PIXEL_MODE: r_pixel_mode <= i_cfg_data[MODE_W-1:0];
                CFG_MAX_SAMPLE: r_max_sample <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ROW_PIXELS: r_row_pixels <= i_cfg_data[DIM_W-1:0];
                CFG_ROW_TOTAL:  r_row_total  <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Scaler start and operand select
    always_comb begin
        div_start  = 1'b0;
        div_sample = r_byte;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (r_pixel_mode == MODE_GRAY)) begin
                    div_start  = 1'b1;
                    div_sample = i_data_byte;
                end else if (accept && (r_pixel_mode == MODE_RGB) && (r_phase == 2'd2)) begin
                    div_start  = 1'b1;
                    div_sample = r_held_red;
                end
            end
            S_DIV: begin
                if (div_done && (r_chan == CH_RED)) begin
                    div_start  = 1'b1;
                    div_sample = r_held_green;
                end else if (div_done && (r_chan == CH_GREEN)) begin
                    div_start  = 1'b1;
                    div_sample = r_byte;
                end
            end
            default: ;
        endcase
    end

    nbpd_scaler u_scaler (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_sample  (div_sample),
        .i_divisor (r_max_sample),
        .o_done    (div_done),
        .o_quot    (div_quot),
        .o_over    (div_over)
    );

    nbpd_raster #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_raster (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row_pixels (r_row_pixels),
        .i_row_total  (r_row_total),
        .i_emit       (emit),
        .o_tag        (tag),
        .o_run_len    (run_len)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_chan       <= CH_RED;
            r_phase      <= 2'd0;
            r_held_red   <= '0;
            r_held_green <= '0;
            r_gray       <= 1'b0;
            r_over       <= 1'b0;
            r_bit_idx    <= '0;
            r_bit_last   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (r_pixel_mode)
                            MODE_BITMAP: begin
                                r_bit_idx  <= '0;
                                r_bit_last <= BIT_IDX_W'(run_len - RUN_W'(1));
                                r_state    <= S_BITS;
                            end
                            MODE_GRAY: begin
                                r_gray  <= 1'b1;
                                r_over  <= 1'b0;
                                r_chan  <= CH_BLUE;
                                r_state <= S_DIV;
                            end
                            MODE_RGB: begin
                                if (r_phase == 2'd0) begin
                                    r_held_red <= i_data_byte;
                                    r_phase    <= 2'd1;
                                end else if (r_phase == 2'd1) begin
                                    r_held_green <= i_data_byte;
                                    r_phase      <= 2'd2;
                                end else begin
                                    r_phase <= 2'd0;
                                    r_gray  <= 1'b0;
                                    r_over  <= 1'b0;
                                    r_chan  <= CH_RED;
                                    r_state <= S_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_over <= r_over | div_over;
                        unique case (r_chan)
                            CH_RED:   r_chan <= CH_GREEN;
                            CH_GREEN: r_chan <= CH_BLUE;
                            CH_BLUE:  r_state <= S_EMIT;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                S_BITS: begin
                    if (out_free) begin
                        r_bit_idx <= r_bit_idx + BIT_IDX_W'(1);
                        if (r_bit_idx == r_bit_last) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Byte holder and scaled samples
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
        end else if ((r_state == S_BITS) && out_free) begin
            r_byte <= {r_byte[SAMPLE_W-2:0], 1'b0};
        end
        if ((r_state == S_DIV) && div_done) begin
            case (r_chan)
                CH_RED:   r_red_q   <= div_quot;
                CH_GREEN: r_green_q <= div_quot;
                default:  r_blue_q  <= div_quot;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_row_end   <= tag.row_end;
            o_image_end <= tag.image_end;
            if (r_state == S_BITS) begin
                o_red      <= bit_val;
                o_green    <= bit_val;
                o_blue     <= bit_val;
                o_over_max <= 1'b0;
                o_run_last <= (r_bit_idx == r_bit_last);
            end else begin
                o_red      <= r_gray ? r_blue_q : r_red_q;
                o_green    <= r_gray ? r_blue_q : r_green_q;
                o_blue     <= r_blue_q;
                o_over_max <= r_over;
                o_run_last <= 1'b1;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

### src/nbpd_scaler.sv
`timescale 1ns / 1ps
// ============================================================================
// nbpd_scaler - iterative sample scaler
// Computes sample*255/max_sample by restoring division, one quotient bit per
// cycle over eight steps. A sample above max_sample saturates to 255.
// ============================================================================
module nbpd_scaler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [nbpd_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic [nbpd_pkg::SAMPLE_W-1:0]    i_divisor,
    output logic                             o_done,
    output logic [nbpd_pkg::SAMPLE_W-1:0]    o_quot,
    output logic                             o_over
);
    import nbpd_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_W;

    logic                  r_busy;
    logic [BIT_IDX_W-1:0]  r_step;
    logic                  r_done;
    logic [SAMPLE_W:0]     r_rem;
    logic [SAMPLE_W-1:0]   r_low;
    logic [SAMPLE_W-1:0]   r_quot;
    logic                  r_sat;
    logic [SAMPLE_W-1:0]   r_div;

    logic [SAMPLE_W-1:0]   div_fix;
    logic [PROD_W-1:0]     prod;
    logic [SAMPLE_W:0]     trial;
    logic                  fits;

    // Zero divisor behaves as one; sample*255 as (sample<<8) - sample
    assign div_fix = (i_divisor == SAMPLE_ZERO) ? SAMPLE_W'(1) : i_divisor;
    assign prod    = {i_sample, SAMPLE_ZERO} - PROD_W'(i_sample);
    assign trial   = {r_rem[SAMPLE_W-1:0], r_low[SAMPLE_W-1]};
    assign fits    = (trial >= {1'b0, r_div});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + BIT_IDX_W'(1);
                if (r_step == {BIT_IDX_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: one restoring step a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, prod[PROD_W-1:SAMPLE_W]};
            r_low  <= prod[SAMPLE_W-1:0];
            r_quot <= '0;
            r_sat  <= (i_sample > div_fix);
            r_div  <= div_fix;
        end else if (r_busy) begin
            r_rem  <= fits ? (trial - {1'b0, r_div}) : trial;
            r_low  <= {r_low[SAMPLE_W-2:0], 1'b0};
            r_quot <= {r_quot[SAMPLE_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? SAMPLE_FULL : r_quot;
    assign o_over = r_sat;

endmodule

### src/nbpd_raster.sv
`timescale 1ns / 1ps
// ============================================================================
// nbpd_raster - raster position tracker
// Holds the column and row counters, tags each emitted pixel with row and
// image end, and gives the number of bitmap pixels left in the row.
// ============================================================================
module nbpd_raster #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [nbpd_pkg::DIM_W-1:0]    i_row_pixels,
    input  logic [nbpd_pkg::DIM_W-1:0]    i_row_total,
    input  logic                          i_emit,
    output nbpd_pkg::t_raster_tag         o_tag,
    output logic [nbpd_pkg::RUN_W-1:0]    o_run_len
);
    import nbpd_pkg::*;

    localparam int WW = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
    localparam int HW = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic [WW-1:0] rp_ext;
    logic [HW-1:0] rt_ext;
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [WW-1:0] col_ext;
    logic [HW-1:0] row_ext;
    logic [WW-1:0] left;
    logic          rend;
    logic          iend;

    // Effective image size, clamped to one and to the maximum
    assign rp_ext = WW'(i_row_pixels);
    assign rt_ext = HW'(i_row_total);
    always_comb begin
        if (rp_ext == '0)                eff_w = WW'(1);
        else if (rp_ext > WW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
        else                             eff_w = rp_ext;
        if (rt_ext == '0)                 eff_h = HW'(1);
        else if (rt_ext > HW'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
        else                              eff_h = rt_ext;
    end

    assign col_ext = WW'(r_col);
    assign row_ext = HW'(r_row);
    assign rend    = ((col_ext + WW'(1)) >= eff_w);
    assign iend    = rend && ((row_ext + HW'(1)) >= eff_h);

    assign o_tag.row_end   = rend;
    assign o_tag.image_end = iend;

    // Bitmap pixels left in the row, at most one byte's worth
    assign left = eff_w - col_ext;
    always_comb begin
        if (eff_w <= col_ext)               o_run_len = RUN_W'(1);
        else if (left > WW'(BITS_PER_BYTE)) o_run_len = BITS_PER_BYTE;
        else                                o_run_len = RUN_W'(left);
    end

    // Counter update per emitted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_emit) begin
            if (rend) begin
                r_col <= '0;
                r_row <= iend ? '0 : (r_row + RW'(1));
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

endmodule

### bench/netpbm_binary_pixel_decoder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// netpbm_binary_pixel_decoder_tb - self-checking bench of the raster decoder
// Feeds raw bitmap, gray and RGB raster bytes under a range of header
// settings, predicts every emitted pixel with its row, image, saturation and
// run flags, and compares each pixel transaction in order. Both sides idle at
// random; one long output stall fills the block and holds off its input.
// ============================================================================
module netpbm_binary_pixel_decoder_tb;
    import nbpd_pkg::*;

    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int RANDOM_ITEMS   = 250;
    localparam int IDLE_PCT       = 36;
    localparam int SETTLE_CYCLES  = 40;     // covers the three-pass RGB latency
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam logic [DIM_W-1:0]  DIM_ALL_ONES = '1;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

    // RGB gathering phases
    localparam logic [1:0] PHASE_RED   = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_BLUE  = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic                row_end;
        logic                image_end;
        logic                over_max;
        logic                run_last;
    } t_pixel;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic [SAMPLE_W-1:0]   i_data_byte = '0;
    logic                  i_ready     = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic [SAMPLE_W-1:0]   o_red;
    logic [SAMPLE_W-1:0]   o_green;
    logic [SAMPLE_W-1:0]   o_blue;
    logic                  o_row_end;
    logic                  o_image_end;
    logic                  o_over_max;
    logic                  o_run_last;

    // Header copy and raster position of the predictor
    logic [MODE_W-1:0]   cfg_mode       = RST_PIXEL_MODE;
    logic [SAMPLE_W-1:0] cfg_max_sample = RST_MAX_SAMPLE;
    logic [DIM_W-1:0]    cfg_row_pixels = RST_ROW_PIXELS;
    logic [DIM_W-1:0]    cfg_row_total  = RST_ROW_TOTAL;
    int                  col_pos        = 0;
    int                  row_pos        = 0;
    logic [1:0]          rgb_phase      = PHASE_RED;
    logic [SAMPLE_W-1:0] held_red       = '0;
    logic [SAMPLE_W-1:0] held_green     = '0;

    t_pixel      pending_pixels[$];
    int          err_cnt      = 0;
    int          src_idle_pct = IDLE_PCT;
    int          snk_idle_pct = IDLE_PCT;
    logic        rx_hold_req  = 1'b0;
    int unsigned cycle_cnt;

    netpbm_binary_pixel_decoder #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end),
        .o_over_max  (o_over_max),
        .o_run_last  (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Width after clamping to 1..MAX_WIDTH
    function automatic int width_eff();
        if (cfg_row_pixels == 0) return 1;
        if (cfg_row_pixels > MAX_WIDTH) return MAX_WIDTH;
        return int'(cfg_row_pixels);
    endfunction

    // {saturated, scaled sample}; a zero maximum counts as one
    function automatic logic [SAMPLE_W:0] scale_sample(input logic [SAMPLE_W-1:0] s);
        int m;
        m = (cfg_max_sample == 0) ? 1 : int'(cfg_max_sample);
        if (int'(s) > m) return {1'b1, SAMPLE_FULL};
        return {1'b0, SAMPLE_W'((int'(s) * int'(SAMPLE_FULL)) / m)};
    endfunction

    // Tag one pixel with its raster position and queue it
    task automatic push_pixel(input logic [SAMPLE_W-1:0] r, g, b, input logic over, last);
        t_pixel px;
        int     h;
        h = (cfg_row_total == 0) ? 1 :
            (cfg_row_total > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_row_total);
        px.red       = r;
        px.green     = g;
        px.blue      = b;
        px.row_end   = (col_pos + 1 >= width_eff());
        px.image_end = 1'b0;
        px.over_max  = over;
        px.run_last  = last;
        if (px.row_end) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                px.image_end = 1'b1;
                row_pos      = 0;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        pending_pixels.push_back(px);
    endtask

    // Pixels caused by one raster byte
    task automatic decode_byte(input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W:0]   rs, gs, bs;
        logic [SAMPLE_W-1:0] v;
        int                  n;
        case (cfg_mode)
            MODE_BITMAP: begin
                n = (width_eff() > col_pos) ? width_eff() - col_pos : 1;
                if (n > BITS_PER_BYTE) n = BITS_PER_BYTE;
                for (int i = 0; i < n; i++) begin
                    v = b[7 - i] ? SAMPLE_FULL : SAMPLE_ZERO;
                    push_pixel(v, v, v, 1'b0, i == n - 1);
                end
            end
            MODE_GRAY: begin
                gs = scale_sample(b);
                push_pixel(gs[7:0], gs[7:0], gs[7:0], gs[8], 1'b1);
            end
            MODE_RGB: begin
                if (rgb_phase == PHASE_RED) begin
                    held_red  = b;
                    rgb_phase = PHASE_GREEN;
                end else if (rgb_phase == PHASE_GREEN) begin
                    held_green = b;
                    rgb_phase  = PHASE_BLUE;
                end else begin
                    rs = scale_sample(held_red);
                    gs = scale_sample(held_green);
                    bs = scale_sample(b);
                    rgb_phase = PHASE_RED;
                    push_pixel(rs[7:0], gs[7:0], bs[7:0], rs[8] | gs[8] | bs[8], 1'b1);
                end
            end
            default: ;  // unused mode: byte dropped, state kept
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one raster byte and hold it until the transaction completes
    task automatic send_byte(input logic [SAMPLE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        decode_byte(b);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Stop offering, wait for every pixel, then let the block go quiet
    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_PIXEL_MODE: cfg_mode       = val[MODE_W-1:0];
            CFG_MAX_SAMPLE: cfg_max_sample = val[SAMPLE_W-1:0];
            CFG_ROW_PIXELS: cfg_row_pixels = val[DIM_W-1:0];
            CFG_ROW_TOTAL:  cfg_row_total  = val[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_image(input logic [MODE_W-1:0] mode, input logic [SAMPLE_W-1:0] maxv,
                             input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
        write_reg(CFG_PIXEL_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_MAX_SAMPLE, CFG_DATA_W'(maxv));
        write_reg(CFG_ROW_PIXELS, cols);
        write_reg(CFG_ROW_TOTAL, rows);
    endtask

    // Output side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                for (int n = 0; n < RX_HOLD_CYCLES; n++) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel with no expectation: rgb %0d %0d %0d", o_red, o_green, o_blue);
                err_cnt++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("red", want.red, o_red);
                check_field("green", want.green, o_green);
                check_field("blue", want.blue, o_blue);
                check_field("row_end", want.row_end, o_row_end);
                check_field("image_end", want.image_end, o_image_end);
                check_field("over_max", want.over_max, o_over_max);
                check_field("run_last", want.run_last, o_run_last);
            end
        end
    end

    // Watchdog
    initial begin
        for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Header defaults after reset: rgb, full-scale maximum, wide image
    task automatic test_reset_defaults();
        send_byte(8'd0);
        send_byte(8'd255);
        send_byte(8'd128);
    endtask

    // Padding bits dropped at row end; clamped widths
    task automatic test_bitmap_rows();
        set_image(MODE_BITMAP, 8'd255, 13'd11, 13'd2);
        send_byte(8'hA5);
        send_byte(8'hFF);               // three pixels then row end
        write_reg(CFG_ROW_PIXELS, '0);  // zero width acts as one
        send_byte(8'h00);
        write_reg(CFG_ROW_PIXELS, DIM_ALL_ONES);  // above the limit
        send_byte(8'h3C);
    endtask

    // Zero maximum, saturation and a zero height
    task automatic test_gray_scaling();
        set_image(MODE_GRAY, 8'd0, 13'd2, 13'd0);
        send_byte(8'd1);
        send_byte(8'd2);
        write_reg(CFG_MAX_SAMPLE, 13'd100);
        send_byte(8'd50);
        send_byte(8'd101);
    endtask

    // One saturated component flags the whole pixel
    task automatic test_rgb_saturation();
        set_image(MODE_RGB, 8'd200, 13'd1, 13'd1);
        send_byte(8'd10);
        send_byte(8'd201);
        send_byte(8'd200);
    endtask

    task automatic test_ignored_mode();
        write_reg(CFG_PIXEL_MODE, CFG_DATA_W'(MODE_UNUSED));
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // Gray byte in the middle of an RGB pixel; the pixel resumes afterwards
    task automatic test_mode_switch_mid_pixel();
        set_image(MODE_RGB, 8'd200, 13'd4, 13'd2);
        send_byte(8'h11);
        send_byte(8'h22);
        write_reg(CFG_PIXEL_MODE, CFG_DATA_W'(MODE_GRAY));
        send_byte(8'h80);
        write_reg(CFG_PIXEL_MODE, CFG_DATA_W'(MODE_RGB));
        send_byte(8'h33);
    endtask

    // Width and height reduced part-way through a row and an image
    task automatic test_shrink_mid_image();
        set_image(MODE_GRAY, 8'd255, 13'd10, DIM_ALL_ONES);
        repeat (3) send_byte(8'($urandom_range(255)));
        write_reg(CFG_ROW_PIXELS, 13'd2);
        send_byte(8'h7F);
        write_reg(CFG_ROW_TOTAL, 13'd1);
        send_byte(8'h01);
        send_byte(8'hFE);
    endtask

    // Long output stall: the held pixel blocks the input side
    task automatic test_backpressure();
        set_image(MODE_GRAY, 8'd255, 13'd3, 13'd2);
        rx_hold_req = 1'b1;
        repeat (6) send_byte(8'($urandom_range(255)));
        drain_and_settle();
    endtask

    // Random headers and raster content, 25 raster bytes per header, 4 for the unused mode
    task automatic test_random_images();
        int                  counted;
        int                  sel;
        int                  lim;
        int                  n_items;
        logic [MODE_W-1:0]   mode;
        logic [SAMPLE_W-1:0] maxv;
        logic [DIM_W-1:0]    cols;
        logic [DIM_W-1:0]    rows;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            sel  = $urandom_range(9);
            mode = (sel < 3) ? MODE_BITMAP : (sel < 6) ? MODE_GRAY :
                   (sel < 9) ? MODE_RGB : MODE_UNUSED;
            sel  = $urandom_range(7);
            maxv = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd1 : (sel == 2) ? 8'd255 :
                   8'($urandom_range(255));
            sel  = $urandom_range(9);
            cols = (sel == 0) ? 13'd0 : (sel == 1) ? 13'(MAX_WIDTH) :
                   (sel == 2) ? DIM_ALL_ONES : 13'($urandom_range(1, 12));
            sel  = $urandom_range(9);
            rows = (sel == 0) ? 13'd0 : (sel == 1) ? DIM_ALL_ONES : 13'($urandom_range(1, 4));
            set_image(mode, maxv, cols, rows);

            // first header runs with no idling on either side
            src_idle_pct = (counted == 0) ? 0 : IDLE_PCT;
            snk_idle_pct = src_idle_pct;

            n_items = (mode == MODE_UNUSED) ? 4 : 25;
            lim     = (maxv + 2 > 255) ? 255 : maxv + 2;
            repeat (n_items) begin
                if ($urandom_range(1)) send_byte(8'($urandom_range(255)));
                else send_byte(8'($urandom_range(lim)));
            end
            if (mode != MODE_UNUSED) counted += n_items;
        end
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_bitmap_rows();
        test_gray_scaling();
        test_rgb_saturation();
        test_ignored_mode();
        test_mode_switch_mid_pixel();
        test_shrink_mid_image();
        test_backpressure();
        test_random_images();

        drain_and_settle();
        if (err_cnt == 0 && pending_pixels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
